// File: design/lpue_pkg.sv
// Shared types, constants and the line-byte encoder for the LED pixel UART encoder.
`timescale 1ns / 1ps

package lpue_pkg;

    // Brightness register
    localparam int unsigned BRIGHT_W = 7;
    localparam logic [BRIGHT_W-1:0] BRIGHT_FULL = 7'd100;

    // Color and channel widths
    localparam int unsigned COLOR_W = 24;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned NUM_CHAN = 3;
    localparam int unsigned PROD_W  = CHAN_W + BRIGHT_W;

    // floor(x / 100) == (x * 5243) >> 19 for every x below 43699
    localparam int unsigned RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int unsigned RECIP_SHIFT = 19;
    localparam int unsigned QPROD_W     = PROD_W + RECIP_W;

    // Line byte layout: b?0?10?10
    localparam int unsigned LINE_W = 8;
    localparam logic [LINE_W-1:0] LINE_BASE  = 8'b0001_0010;
    localparam logic [LINE_W-1:0] LINE_BIT_A = 8'b0000_0100;
    localparam logic [LINE_W-1:0] LINE_BIT_B = 8'b0010_0000;
    localparam logic [LINE_W-1:0] LINE_BIT_C = 8'b1000_0000;

    // Serializer
    localparam int unsigned GRP_W       = 3;
    localparam int unsigned BYTES_PER_PX = 8;
    localparam int unsigned IDX_W       = 3;
    localparam logic [IDX_W-1:0] IDX_LAST = 3'd7;

    // Scaled pixel handed from the scaling pipeline to the serializer
    typedef struct packed {
        logic [COLOR_W-1:0] grb;
        logic               last;
    } t_pix;

    // Encode one group of three data bits, first bit in grp[2]
    function automatic logic [LINE_W-1:0] enc_group(input logic [GRP_W-1:0] grp);
        logic [LINE_W-1:0] t;
        t = LINE_BASE;
        if (grp[2]) t = t | LINE_BIT_A;
        if (grp[1]) t = t | LINE_BIT_B;
        if (grp[0]) t = t | LINE_BIT_C;
        return t;
    endfunction

endpackage

// File: design/lpue_scale.sv
// Three-stage brightness scaling pipeline: multiply, reciprocal multiply, select and reorder.
`timescale 1ns / 1ps

module lpue_scale (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [lpue_pkg::BRIGHT_W-1:0]     i_brightness,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [lpue_pkg::COLOR_W-1:0]      i_color,
    input  logic                              i_last,
    output logic                              o_valid,
    input  logic                              i_ready,
    output lpue_pkg::t_pix                    o_pix
);

    // Stage 1: channel times percent
    logic                              r_s1_valid;
    logic [lpue_pkg::PROD_W-1:0]       r_s1_prod [lpue_pkg::NUM_CHAN];
    logic [lpue_pkg::COLOR_W-1:0]      r_s1_rgb;
    logic                              r_s1_pass;
    logic                              r_s1_last;

    // Stage 2: product times reciprocal of one hundred
    logic                              r_s2_valid;
    logic [lpue_pkg::QPROD_W-1:0]      r_s2_q [lpue_pkg::NUM_CHAN];
    logic [lpue_pkg::COLOR_W-1:0]      r_s2_rgb;
    logic                              r_s2_pass;
    logic                              r_s2_last;

    // Stage 3: scaled pixel in GRB order
    logic                              r_s3_valid;
    lpue_pkg::t_pix                    r_s3_pix;

    logic                              s1_adv;
    logic                              s2_adv;
    logic                              s3_adv;
    logic [lpue_pkg::COLOR_W-1:0]      n_rgb;
    logic [lpue_pkg::CHAN_W-1:0]       scaled [lpue_pkg::NUM_CHAN];

    // Each stage moves when its successor is empty or moving
    assign s3_adv  = !r_s3_valid || i_ready;
    assign s2_adv  = !r_s2_valid || s3_adv;
    assign s1_adv  = !r_s1_valid || s2_adv;
    assign o_ready = s1_adv;
    assign o_valid = r_s3_valid;
    assign o_pix   = r_s3_pix;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (s1_adv) r_s1_valid <= i_valid;
            if (s2_adv) r_s2_valid <= r_s1_valid;
            if (s3_adv) r_s3_valid <= r_s2_valid;
        end
    end

    // Per-channel multiplies
    for (genvar c = 0; c < lpue_pkg::NUM_CHAN; c++) begin : g_chan
        always_ff @(posedge i_clk) begin
            if (s1_adv) begin
                r_s1_prod[c] <= lpue_pkg::PROD_W'(i_color[c*lpue_pkg::CHAN_W +: lpue_pkg::CHAN_W])
                              * lpue_pkg::PROD_W'(i_brightness);
            end
            if (s2_adv) begin
                r_s2_q[c] <= lpue_pkg::QPROD_W'(r_s1_prod[c])
                           * lpue_pkg::QPROD_W'(lpue_pkg::RECIP_100);
            end
        end
        assign scaled[c] = r_s2_q[c][lpue_pkg::RECIP_SHIFT +: lpue_pkg::CHAN_W];
    end

    // Carry the raw color and flags alongside
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1_rgb  <= i_color;
            r_s1_pass <= (i_brightness >= lpue_pkg::BRIGHT_FULL);
            r_s1_last <= i_last;
        end
        if (s2_adv) begin
            r_s2_rgb  <= r_s1_rgb;
            r_s2_pass <= r_s1_pass;
            r_s2_last <= r_s1_last;
        end
    end

    // Pick raw or scaled color, reorder to GRB
    always_comb begin
        if (r_s2_pass) begin
            n_rgb = r_s2_rgb;
        end else begin
            n_rgb = {scaled[2], scaled[1], scaled[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_adv) begin
            r_s3_pix.grb  <= {n_rgb[15:8], n_rgb[23:16], n_rgb[7:0]};
            r_s3_pix.last <= r_s2_last;
        end
    end

endmodule

// File: design/lpue_ser.sv
// Serializer: splits one GRB pixel into eight line bytes behind an output register.
`timescale 1ns / 1ps

module lpue_ser (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  lpue_pkg::t_pix                 i_pix,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [lpue_pkg::LINE_W-1:0]    o_line_byte,
    output logic                           o_pixel_last_byte,
    output logic                           o_frame_end
);

    logic                              r_act;
    logic [lpue_pkg::IDX_W-1:0]        r_idx;
    logic [lpue_pkg::COLOR_W-1:0]      r_grb;
    logic                              r_last;

    logic                              r_out_valid;
    logic [lpue_pkg::LINE_W-1:0]       r_out_byte;
    logic                              r_out_plast;
    logic                              r_out_fend;

    logic                              out_load;
    logic                              emit;
    logic                              finish;

    // Output register takes a new byte when empty or being drained
    assign out_load = !r_out_valid || i_ready;
    assign emit     = r_act && out_load;
    assign finish   = emit && (r_idx == lpue_pkg::IDX_LAST);
    assign o_ready  = !r_act || finish;

    assign o_valid           = r_out_valid;
    assign o_line_byte       = r_out_byte;
    assign o_pixel_last_byte = r_out_plast;
    assign o_frame_end       = r_out_fend;

    // Control: active flag, byte index, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act       <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_act <= i_valid;
                r_idx <= '0;
            end else if (emit) begin
                r_idx <= r_idx + 1'b1;
            end
            if (out_load) r_out_valid <= r_act;
        end
    end

    // Load a pixel or shift out the group just sent
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_grb  <= i_pix.grb;
            r_last <= i_pix.last;
        end else if (emit) begin
            r_grb <= {r_grb[lpue_pkg::COLOR_W-lpue_pkg::GRP_W-1:0], lpue_pkg::GRP_W'(0)};
        end
    end

    // Encode the leading group into the output register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte  <= lpue_pkg::enc_group(
                               r_grb[lpue_pkg::COLOR_W-1 -: lpue_pkg::GRP_W]);
            r_out_plast <= (r_idx == lpue_pkg::IDX_LAST);
            r_out_fend  <= (r_idx == lpue_pkg::IDX_LAST) && r_last;
        end
    end

endmodule

// File: design/led_pixel_uart_encoder.sv
// Top level of the LED pixel UART encoder: brightness register, scaling pipeline, serializer.
//
//  channel | ports                                           | direction
//  --------+-------------------------------------------------+----------
//  cfg     | i_cfg_valid, o_cfg_ready, i_cfg_data            | in
//  pixel   | i_in_valid, o_in_ready, i_pixel_color,          | in
//          | i_frame_last_pixel                              |
//  line    | o_out_valid, i_out_ready, o_line_byte,          | out
//          | o_pixel_last_byte, o_frame_end                  |
//
// Each pixel item yields eight line bytes, one per cycle while the output is not
// stalled; the serializer takes the next pixel in the same cycle that it emits the
// last byte of the current one. The first byte passes from the first scaling stage,
// loaded at the accepting edge, through two more scaling stages, the serializer's
// pixel register and the output register. Synchronous active-low reset
// empties all stages and sets brightness to 100. A stalled output holds its byte;
// stages behind it fill and then hold, nothing is dropped or repeated.
`timescale 1ns / 1ps

module led_pixel_uart_encoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lpue_pkg::BRIGHT_W-1:0]  i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [lpue_pkg::COLOR_W-1:0]   i_pixel_color,
    input  logic                           i_frame_last_pixel,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [lpue_pkg::LINE_W-1:0]    o_line_byte,
    output logic                           o_pixel_last_byte,
    output logic                           o_frame_end
);

    logic [lpue_pkg::BRIGHT_W-1:0]  r_brightness;
    logic                           pix_valid;
    logic                           pix_ready;
    lpue_pkg::t_pix                 pix;

    // Brightness register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= lpue_pkg::BRIGHT_FULL;
        end else if (i_cfg_valid) begin
            r_brightness <= i_cfg_data;
        end
    end

    // Scale and reorder
    lpue_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_brightness (r_brightness),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_color      (i_pixel_color),
        .i_last       (i_frame_last_pixel),
        .o_valid      (pix_valid),
        .i_ready      (pix_ready),
        .o_pix        (pix)
    );

    // Split into line bytes
    lpue_ser u_ser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (pix_valid),
        .o_ready           (pix_ready),
        .i_pix             (pix),
        .o_valid           (o_out_valid),
        .i_ready           (i_out_ready),
        .o_line_byte       (o_line_byte),
        .o_pixel_last_byte (o_pixel_last_byte),
        .o_frame_end       (o_frame_end)
    );

endmodule
